[hw/rtl/sm4bc_pkg.sv]
// Package for the SM4 block cipher: payload types, state codes, S-box and round functions.
package sm4bc_pkg;

  localparam int unsigned Rounds    = 32;
  localparam int unsigned RoundBits = $clog2(Rounds);
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = CfgIdxW'(1);

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        decrypt;
  } in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_t;

  typedef enum logic [1:0] {
    ST_EXPAND,
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  function automatic logic [31:0] tau(logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [31:0] rol32(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] lin_data(logic [31:0] b);
    return b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
  endfunction

  function automatic logic [31:0] lin_key(logic [31:0] b);
    return b ^ rol32(b, 13) ^ rol32(b, 23);
  endfunction

  function automatic logic [31:0] ck_word(logic [RoundBits-1:0] i);
    logic [7:0]  pos;
    logic [7:0]  b;
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      pos = 8'({i, 2'(j)});
      b   = pos * 8'd7;
      w   = {w[23:0], b};
    end
    return w;
  endfunction

endpackage

[hw/rtl/sm4_block_crypt.sv]
// SM4 block cipher, ECB, with round keys held in a synchronous memory with one write and one read port.
//
// One 128-bit block is encrypted or decrypted per transfer with the key held in
// registers 0 (key_high) and 1 (key_low). After reset and after every key write the
// 32 round keys are expanded into the round-key memory, one key per cycle, and input
// stalls while they are expanded. A block then runs one round per cycle through a
// single shared round unit, fed by one round-key memory read per cycle; the result
// goes to the output register once the rounds end and that register is free, and no
// new block is taken before then. The output register holds a finished result while the next block is taken.
module sm4_block_crypt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sm4bc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sm4bc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  sm4bc_pkg::in_t                   in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output sm4bc_pkg::out_t                  out_data_o
);

  localparam int unsigned RB = sm4bc_pkg::RoundBits;
  localparam logic [RB-1:0] LastRound = RB'(sm4bc_pkg::Rounds - 1);

  sm4bc_pkg::state_e state_q, state_d;

  logic [63:0]   key_high_q, key_high_d;
  logic [63:0]   key_low_q, key_low_d;
  logic [31:0]   k_q [4];
  logic [31:0]   x_q [4];
  logic [RB-1:0] cnt_q, cnt_d;
  logic          dec_q;
  logic [31:0]   rk_q;
  logic          out_valid_q;
  sm4bc_pkg::out_t out_q;

  logic [31:0]   rk_mem [sm4bc_pkg::Rounds];

  logic          cfg_hit;
  logic          in_take;
  logic          out_take;
  logic          out_free;
  logic          do_expand;
  logic          do_round;
  logic          do_load;
  logic [RB-1:0] rd_idx;
  logic [RB-1:0] rd_addr;
  logic          rd_dec;
  logic [31:0]   mix_in;
  logic [31:0]   sub;
  logic [31:0]   new_key;
  logic [31:0]   new_x;

  assign cfg_hit = cfg_we_i && ((cfg_index_i == sm4bc_pkg::CFG_KEY_HIGH) ||
                                (cfg_index_i == sm4bc_pkg::CFG_KEY_LOW));
  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    key_high_d = key_high_q;
    key_low_d  = key_low_q;
    if (cfg_we_i && (cfg_index_i == sm4bc_pkg::CFG_KEY_HIGH)) begin
      key_high_d = cfg_data_i;
    end
    if (cfg_we_i && (cfg_index_i == sm4bc_pkg::CFG_KEY_LOW)) begin
      key_low_d = cfg_data_i;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    priority if (cfg_hit) begin
      state_d = sm4bc_pkg::ST_EXPAND;
      cnt_d   = '0;
    end else begin
      unique case (state_q)
        sm4bc_pkg::ST_EXPAND: begin
          cnt_d = cnt_q + RB'(1);
          if (cnt_q == LastRound) begin
            state_d = sm4bc_pkg::ST_IDLE;
          end
        end
        sm4bc_pkg::ST_IDLE: begin
          cnt_d = '0;
          if (in_take) begin
            state_d = sm4bc_pkg::ST_RUN;
          end
        end
        sm4bc_pkg::ST_RUN: begin
          cnt_d = cnt_q + RB'(1);
          if (cnt_q == LastRound) begin
            state_d = sm4bc_pkg::ST_FINISH;
          end
        end
        sm4bc_pkg::ST_FINISH: begin
          if (out_free) begin
            state_d = sm4bc_pkg::ST_IDLE;
          end
        end
        default: state_d = sm4bc_pkg::ST_IDLE;
      endcase
    end
  end

  always_comb begin
    in_stall_o = 1'b1;
    do_expand  = 1'b0;
    do_round   = 1'b0;
    do_load    = 1'b0;
    unique case (state_q)
      sm4bc_pkg::ST_EXPAND: do_expand  = 1'b1;
      sm4bc_pkg::ST_IDLE:   in_stall_o = 1'b0;
      sm4bc_pkg::ST_RUN:    do_round   = 1'b1;
      sm4bc_pkg::ST_FINISH: do_load    = out_free;
      default:              in_stall_o = 1'b1;
    endcase
  end

  assign rd_idx  = (state_q == sm4bc_pkg::ST_IDLE) ? '0 : cnt_q + RB'(1);
  assign rd_dec  = (state_q == sm4bc_pkg::ST_IDLE) ? in_data_i.decrypt : dec_q;
  assign rd_addr = rd_dec ? ~rd_idx : rd_idx;

  assign mix_in  = do_expand ? (k_q[1] ^ k_q[2] ^ k_q[3] ^ sm4bc_pkg::ck_word(cnt_q))
                             : (x_q[1] ^ x_q[2] ^ x_q[3] ^ rk_q);
  assign sub     = sm4bc_pkg::tau(mix_in);
  assign new_key = k_q[0] ^ sm4bc_pkg::lin_key(sub);
  assign new_x   = x_q[0] ^ sm4bc_pkg::lin_data(sub);

  always_ff @(posedge clk_i) begin
    if (do_expand) begin
      rk_mem[cnt_q] <= new_key;
    end
    rk_q <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sm4bc_pkg::ST_EXPAND;
      cnt_q       <= '0;
      key_high_q  <= '0;
      key_low_q   <= '0;
      k_q[0]      <= sm4bc_pkg::FK0;
      k_q[1]      <= sm4bc_pkg::FK1;
      k_q[2]      <= sm4bc_pkg::FK2;
      k_q[3]      <= sm4bc_pkg::FK3;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      key_high_q <= key_high_d;
      key_low_q  <= key_low_d;
      if (cfg_hit) begin
        k_q[0] <= key_high_d[63:32] ^ sm4bc_pkg::FK0;
        k_q[1] <= key_high_d[31:0]  ^ sm4bc_pkg::FK1;
        k_q[2] <= key_low_d[63:32]  ^ sm4bc_pkg::FK2;
        k_q[3] <= key_low_d[31:0]   ^ sm4bc_pkg::FK3;
      end else if (do_expand) begin
        k_q[0] <= k_q[1];
        k_q[1] <= k_q[2];
        k_q[2] <= k_q[3];
        k_q[3] <= new_key;
      end
      if (do_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q[0] <= in_data_i.block_high[63:32];
      x_q[1] <= in_data_i.block_high[31:0];
      x_q[2] <= in_data_i.block_low[63:32];
      x_q[3] <= in_data_i.block_low[31:0];
      dec_q  <= in_data_i.decrypt;
    end else if (do_round) begin
      x_q[0] <= x_q[1];
      x_q[1] <= x_q[2];
      x_q[2] <= x_q[3];
      x_q[3] <= new_x;
    end
    if (do_load) begin
      out_q.result_high <= {x_q[3], x_q[2]};
      out_q.result_low  <= {x_q[1], x_q[0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
